FILE: hw/rtl/polygon_rect_clipper_assert.svh
// Assertion macros used by the checker file.
`ifndef POLYGON_RECT_CLIPPER_ASSERT_SVH
`define POLYGON_RECT_CLIPPER_ASSERT_SVH

// Same-cycle implication.
`define PRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prc_pkg.sv
`timescale 1ns / 1ps
package prc_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int CFG_ADDR_W       = 3;
    localparam logic [14:0] WIDTH_RST  = 15'd640;
    localparam logic [14:0] HEIGHT_RST = 15'd480;
    localparam int DIV_STEPS = 35;

    localparam logic [1:0] PASS_TOP    = 2'd0;
    localparam logic [1:0] PASS_RIGHT  = 2'd1;
    localparam logic [1:0] PASS_BOTTOM = 2'd2;
    localparam logic [1:0] PASS_LEFT   = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               vertex_last;
    } vtx_in_t;

    typedef struct packed {
        logic signed [15:0] clipped_x;
        logic signed [15:0] clipped_y;
        logic               result_last;
        logic               polygon_empty;
        logic               overflowed;
    } vtx_out_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_FETCHP,
        BK_PREV,
        BK_FETCH,
        BK_CUR,
        BK_MUL,
        BK_DINIT,
        BK_DIV,
        BK_XING,
        BK_KEEP,
        BK_NEXT,
        BK_EFETCH,
        BK_EMIT,
        BK_EMPTY
    } bk_state_t;

    function automatic logic is_in(input logic [1:0] pass,
                                   input logic signed [15:0] x,
                                   input logic signed [15:0] y,
                                   input logic [14:0] w,
                                   input logic [14:0] h);
        logic r;
        case (pass)
            PASS_TOP:    r = (y >= 16'sd0);
            PASS_RIGHT:  r = ($signed({x[15], x}) <= $signed({2'b00, w}));
            PASS_BOTTOM: r = ($signed({y[15], y}) <= $signed({2'b00, h}));
            default:     r = (x >= 16'sd0);
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/prc_ram.sv
`timescale 1ns / 1ps
module prc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/prc_front.sv
`timescale 1ns / 1ps
module prc_front #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  prc_pkg::vtx_in_t                   in_data,
    input  logic                               hold,
    output logic                               wr_en,
    output logic [$clog2(MAX_VERTICES)-1:0]    wr_addr,
    output logic [31:0]                        wr_data,
    output logic                               job_push,
    output logic [$clog2(MAX_VERTICES+1):0]    job_data
);
    import prc_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             acc;
    logic             room;

    assign in_stall = hold;
    assign acc      = in_valid && !hold;
    assign room     = (count_reg < CNT_W'(MAX_VERTICES));
    assign wr_en    = acc && room;
    assign wr_addr  = count_reg[IDX_W-1:0];
    assign wr_data  = {in_data.vertex_y, in_data.vertex_x};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (acc)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign job_push = acc && in_data.vertex_last;
    assign job_data = {ovf_next, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (job_push)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule

FILE: hw/rtl/prc_job_fifo.sv
`timescale 1ns / 1ps
module prc_job_fifo #(
    parameter int WIDTH = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hw/rtl/prc_back.sv
`timescale 1ns / 1ps
module prc_back #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [14:0]                        win_w,
    input  logic [14:0]                        win_h,
    input  logic                               fe_wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]    fe_wr_addr,
    input  logic [31:0]                        fe_wr_data,
    input  logic                               job_valid,
    input  logic [$clog2(MAX_VERTICES+1):0]    job_data,
    output logic                               job_pop,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output prc_pkg::vtx_out_t                  out_data
);
    import prc_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);

    bk_state_t state_reg, state_next;

    logic [1:0]        pass_reg, pass_next;
    logic [CNT_W-1:0]  n_reg, n_next, m_reg, m_next, idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic [31:0]       prev_reg, prev_next, cur_reg, cur_next;
    logic              cin_reg, cin_next;
    logic signed [34:0] prod_reg;
    logic [16:0]       dmag_reg;
    logic              neg_reg;
    logic [34:0]       quo_reg, quo_next;
    logic [16:0]       rem_reg, rem_next;
    logic [5:0]        dcnt_reg, dcnt_next;
    logic              outv_reg, outv_next;
    vtx_out_t          outd_reg, outd_next;

    logic [IDX_W-1:0]  rd_addr;
    logic [31:0]       a_rdata, b_rdata, src_rdata;
    logic              a_we, b_we;
    logic [IDX_W-1:0]  a_waddr, b_waddr;
    logic [31:0]       a_wdata;
    logic              app_en;
    logic [31:0]       app_data;
    logic              app_full;
    logic              out_free;

    // crossing arithmetic
    logic               horiz;
    logic signed [15:0] cx, cy, px, py;
    logic signed [16:0] bnd;
    logic signed [16:0] mul_a, den;
    logic signed [17:0] mul_b;
    logic signed [34:0] prod;
    logic [17:0]        shl;
    logic [16:0]        qv;
    logic signed [17:0] coord;
    logic [15:0]        bnd16;

    prc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    prc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (app_data),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    assign busy      = (state_reg != BK_IDLE);
    assign src_rdata = pass_reg[0] ? b_rdata : a_rdata;
    assign out_free  = !outv_reg || !out_stall;
    assign out_valid = outv_reg;
    assign out_data  = outd_reg;

    // drop the write once the pass output is full
    assign app_full = (m_reg >= CNT_W'(MAX_VERTICES));

    // Odd passes write buffer A, even passes buffer B; the front end owns A while idle.
    assign a_we    = busy ? (app_en && !app_full && pass_reg[0]) : fe_wr_en;
    assign a_waddr = busy ? m_reg[IDX_W-1:0] : fe_wr_addr;
    assign a_wdata = busy ? app_data : fe_wr_data;
    assign b_we    = app_en && !app_full && !pass_reg[0];
    assign b_waddr = m_reg[IDX_W-1:0];

    assign horiz = !pass_reg[0];
    assign cx    = cur_reg[15:0];
    assign cy    = cur_reg[31:16];
    assign px    = prev_reg[15:0];
    assign py    = prev_reg[31:16];

    always_comb
    begin
        case (pass_reg)
            PASS_RIGHT:  bnd = {2'b00, win_w};
            PASS_BOTTOM: bnd = {2'b00, win_h};
            default:     bnd = 17'sd0;
        endcase
    end

    assign mul_a = horiz ? (17'(px) - 17'(cx)) : (17'(py) - 17'(cy));
    assign mul_b = horiz ? (18'(bnd) - 18'(cy)) : (18'(bnd) - 18'(cx));
    assign den   = horiz ? (17'(py) - 17'(cy)) : (17'(px) - 17'(cx));
    assign prod  = mul_a * mul_b;
    assign shl   = {rem_reg, quo_reg[34]};
    assign qv    = neg_reg ? (17'd0 - quo_reg[16:0]) : quo_reg[16:0];
    assign coord = (horiz ? 18'(cx) : 18'(cy)) + 18'($signed(qv));
    assign bnd16 = bnd[15:0];

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        cin_next   = cin_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        outv_next  = outv_reg && out_stall;
        outd_next  = outd_reg;
        rd_addr    = idx_reg[IDX_W-1:0];
        app_en     = 1'b0;
        app_data   = cur_reg;
        job_pop    = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    n_next    = job_data[CNT_W-1:0];
                    ovf_next  = job_data[CNT_W];
                    pass_next = PASS_TOP;
                    m_next    = '0;
                    state_next = (job_data[CNT_W-1:0] == '0) ? BK_EMPTY : BK_FETCHP;
                end
            end
            BK_FETCHP:
            begin
                rd_addr    = IDX_W'(n_reg - 1'b1);
                state_next = BK_PREV;
            end
            BK_PREV:
            begin
                prev_next  = src_rdata;
                idx_next   = '0;
                state_next = BK_FETCH;
            end
            BK_FETCH:
            begin
                state_next = BK_CUR;
            end
            BK_CUR:
            begin
                cur_next = src_rdata;
                cin_next = is_in(pass_reg, src_rdata[15:0], src_rdata[31:16], win_w, win_h);
                if (cin_next != is_in(pass_reg, px, py, win_w, win_h))
                begin
                    state_next = BK_MUL;
                end
                else
                begin
                    if (cin_next)
                    begin
                        app_en   = 1'b1;
                        app_data = src_rdata;
                    end
                    state_next = BK_NEXT;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DINIT;
            end
            BK_DINIT:
            begin
                quo_next   = prod_reg[34] ? 35'(-prod_reg) : 35'(prod_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (shl >= {1'b0, dmag_reg})
                begin
                    rem_next = 17'(shl - {1'b0, dmag_reg});
                    quo_next = {quo_reg[33:0], 1'b1};
                end
                else
                begin
                    rem_next = shl[16:0];
                    quo_next = {quo_reg[33:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = BK_XING;
                end
            end
            BK_XING:
            begin
                app_en     = 1'b1;
                app_data   = horiz ? {bnd16, coord[15:0]} : {coord[15:0], bnd16};
                state_next = cin_reg ? BK_KEEP : BK_NEXT;
            end
            BK_KEEP:
            begin
                app_en     = 1'b1;
                state_next = BK_NEXT;
            end
            BK_NEXT:
            begin
                prev_next = cur_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_next == n_reg)
                begin
                    n_next   = m_reg;
                    m_next   = '0;
                    idx_next = '0;
                    if (m_reg == '0)
                    begin
                        state_next = BK_EMPTY;
                    end
                    else if (pass_reg == PASS_LEFT)
                    begin
                        state_next = BK_EFETCH;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = BK_FETCHP;
                    end
                end
                else
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_EFETCH:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    outv_next = 1'b1;
                    outd_next.clipped_x     = a_rdata[15:0];
                    outd_next.clipped_y     = a_rdata[31:16];
                    outd_next.result_last   = (idx_reg + 1'b1 == n_reg);
                    outd_next.polygon_empty = 1'b0;
                    outd_next.overflowed    = ovf_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == n_reg) ? BK_IDLE : BK_EFETCH;
                end
            end
            BK_EMPTY:
            begin
                if (out_free)
                begin
                    outv_next = 1'b1;
                    outd_next.clipped_x     = '0;
                    outd_next.clipped_y     = '0;
                    outd_next.result_last   = 1'b1;
                    outd_next.polygon_empty = 1'b1;
                    outd_next.overflowed    = ovf_reg;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (app_en)
        begin
            if (!app_full)
            begin
                m_next = m_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_MUL)
        begin
            prod_reg <= prod;
            dmag_reg <= den[16] ? 17'(-den) : den;
            neg_reg  <= mul_a[16] ^ mul_b[17] ^ den[16];
        end
        pass_reg <= pass_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        cin_reg  <= cin_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        outd_reg <= outd_next;
        m_reg    <= m_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ovf_reg   <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            outv_reg  <= outv_next;
        end
    end
endmodule

FILE: hw/rtl/polygon_rect_clipper.sv
`timescale 1ns / 1ps
// Clips one closed polygon to the window 0..window_width by 0..window_height in four
// passes (top, right, bottom, left); vertices on a boundary count as inside. Vertices
// stream in one per transfer while the clip engine is idle; the transfer carrying
// vertex_last starts the clip, and input stalls until the last result of the polygon
// has been loaded into the output register. Each pass fetches the closing vertex first,
// then fetches, tests and advances per vertex; each edge crossing adds a multiply, the
// 35-step bit-serial divider that computes it and its write, plus a write when the current
// vertex is kept after it. Results leave one by one from an output register and hold
// under output stalls. Vertices or pass outputs beyond MAX_VERTICES are dropped and
// flagged through overflowed on every result of that polygon.
module polygon_rect_clipper #(
    parameter int MAX_VERTICES = prc_pkg::MAX_VERTICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  prc_pkg::vtx_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output prc_pkg::vtx_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import prc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int JOB_W = $clog2(MAX_VERTICES + 1) + 1;

    logic [14:0]      win_w_reg, win_h_reg;
    logic             wr_en, job_push, job_pop, job_valid, busy;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [JOB_W-1:0] job_in, job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {17'd0, win_h_reg} : {17'd0, win_w_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= WIDTH_RST;
            win_h_reg <= HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                win_w_reg <= pwdata[14:0];
            end
            else
            begin
                win_h_reg <= pwdata[14:0];
            end
        end
    end

    prc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .hold     (busy || job_valid),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .job_push (job_push),
        .job_data (job_in)
    );

    prc_job_fifo #(.WIDTH(JOB_W)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .not_empty (job_valid)
    );

    prc_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_w      (win_w_reg),
        .win_h      (win_h_reg),
        .fe_wr_en   (wr_en),
        .fe_wr_addr (wr_addr),
        .fe_wr_data (wr_data),
        .job_valid  (job_valid),
        .job_data   (job_out),
        .job_pop    (job_pop),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );
endmodule

FILE: hw/rtl/prc_checker.sv
`timescale 1ns / 1ps
`include "polygon_rect_clipper_assert.svh"
module prc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input prc_pkg::vtx_out_t out_data
);
    `PRC_ASSERT_IMP(a_empty_last, out_valid && out_data.polygon_empty, out_data.result_last, "empty result not last")
    `PRC_ASSERT_IMP(a_empty_zero, out_valid && out_data.polygon_empty, out_data.clipped_x == 16'sd0 && out_data.clipped_y == 16'sd0, "empty result has coordinates")
    `PRC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `PRC_ASSERT_IMP(a_busy_in, out_valid && !out_data.result_last, in_stall, "input taken mid-polygon output")
endmodule

bind polygon_rect_clipper prc_checker u_prc_checker (.*);

FILE: bench/tb_polygon_rect_clipper.sv
`timescale 1ns / 1ps
module tb_polygon_rect_clipper;
    import prc_pkg::*;

    localparam int MAXV = MAX_VERTICES_DEF;
    localparam int IDLE_LIMIT = 200000;
    localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH = CFG_ADDR_W'(4 * REG_WIDTH);
    localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = CFG_ADDR_W'(4 * REG_HEIGHT);

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    vtx_in_t in_data;
    logic out_valid;
    logic out_stall;
    vtx_out_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    polygon_rect_clipper u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor state
    int win_w;
    int win_h;
    int poly_x[$];
    int poly_y[$];
    bit poly_drop;

    vtx_in_t pending_vertices[$];
    vtx_out_t expected_clips[$];
    int mismatches;
    bit failed;
    int idle_pct_in;
    int idle_pct_out;
    int quiet_cycles;
    bit accepting_done;

    function automatic bit inside_edge(int pass, int x, int y);
        case (pass)
            PASS_TOP:    return y >= 0;
            PASS_RIGHT:  return x <= win_w;
            PASS_BOTTOM: return y <= win_h;
            default:     return x >= 0;
        endcase
    endfunction

    // edge crossing from current vertex toward previous, truncating division
    function automatic void edge_cross(int pass, int cx, int cy, int px, int py,
                                       output int rx, output int ry);
        longint b;
        longint num;
        longint den;
        if (pass == PASS_TOP || pass == PASS_BOTTOM) begin
            b = (pass == PASS_TOP) ? 0 : win_h;
            den = py - cy;
            if (den == 0) begin
                rx = cx; ry = cy;
            end else begin
                num = longint'(px - cx) * (b - cy);
                rx = int'(cx + num / den); ry = int'(b);
            end
        end else begin
            b = (pass == PASS_RIGHT) ? win_w : 0;
            den = px - cx;
            if (den == 0) begin
                rx = cx; ry = cy;
            end else begin
                num = longint'(py - cy) * (b - cx);
                ry = int'(cy + num / den); rx = int'(b);
            end
        end
    endfunction

    task automatic clip_polygon();
        int sx[$];
        int sy[$];
        int dx[$];
        int dy[$];
        int j;
        int ix;
        int iy;
        bit cin;
        bit pin;
        vtx_out_t r;
        sx = poly_x;
        sy = poly_y;
        for (int pass = 0; pass < 4; pass++) begin
            dx.delete();
            dy.delete();
            for (int i = 0; i < sx.size(); i++) begin
                j = (i == 0) ? sx.size() - 1 : i - 1;
                cin = inside_edge(pass, sx[i], sy[i]);
                pin = inside_edge(pass, sx[j], sy[j]);
                if (cin != pin) begin
                    edge_cross(pass, sx[i], sy[i], sx[j], sy[j], ix, iy);
                    if (dx.size() < MAXV) begin
                        dx.push_back(ix); dy.push_back(iy);
                    end else poly_drop = 1'b1;
                end
                if (cin) begin
                    if (dx.size() < MAXV) begin
                        dx.push_back(sx[i]); dy.push_back(sy[i]);
                    end else poly_drop = 1'b1;
                end
            end
            sx = dx;
            sy = dy;
        end
        if (sx.size() == 0) begin
            r = '0;
            r.result_last = 1'b1;
            r.polygon_empty = 1'b1;
            r.overflowed = poly_drop;
            expected_clips.push_back(r);
        end else begin
            for (int k = 0; k < sx.size(); k++) begin
                r.clipped_x = 16'(sx[k]);
                r.clipped_y = 16'(sy[k]);
                r.result_last = (k == sx.size() - 1);
                r.polygon_empty = 1'b0;
                r.overflowed = poly_drop;
                expected_clips.push_back(r);
            end
        end
        poly_x.delete();
        poly_y.delete();
        poly_drop = 1'b0;
    endtask

    task automatic take_vertex(vtx_in_t v);
        if (poly_x.size() < MAXV) begin
            poly_x.push_back(int'(v.vertex_x));
            poly_y.push_back(int'(v.vertex_y));
        end else poly_drop = 1'b1;
        if (v.vertex_last) clip_polygon();
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct_in) begin
                    in_data <= pending_vertices.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct_out);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && !in_stall) begin
                take_vertex(in_data);
            end
            if (out_valid && !out_stall) begin
                if (expected_clips.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%0d y=%0d", out_data.clipped_x,
                                 out_data.clipped_y);
                end else begin
                    vtx_out_t e;
                    e = expected_clips.pop_front();
                    if (e !== out_data) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp x=%0d y=%0d l=%b e=%b o=%b got x=%0d y=%0d l=%b e=%b o=%b",
                                     e.clipped_x, e.clipped_y, e.result_last,
                                     e.polygon_empty, e.overflowed,
                                     out_data.clipped_x, out_data.clipped_y,
                                     out_data.result_last, out_data.polygon_empty,
                                     out_data.overflowed);
                    end
                end
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [CFG_ADDR_W-1:0] a, logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == ADDR_WIDTH) win_w = d[14:0];
        else win_h = d[14:0];
    endtask

    task automatic drain();
        while (pending_vertices.size() > 0 || in_valid || expected_clips.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic push_vtx(int x, int y, bit last);
        vtx_in_t v;
        v.vertex_x = 16'(x);
        v.vertex_y = 16'(y);
        v.vertex_last = last;
        pending_vertices.push_back(v);
    endtask

    function automatic int rand_coord(int lim);
        case ($urandom_range(9))
            0: return $signed(16'($urandom));
            1: return $urandom_range(1) ? -32768 : 32767;
            2: return $urandom_range(1) ? 0 : lim;
            default: return int'($urandom_range(lim + 200)) - 100;
        endcase
    endfunction

    task automatic random_polygons(int items);
        int n;
        int lim;
        while (items > 0) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 8);
            lim = (win_w > win_h) ? win_w : win_h;
            for (int i = 0; i < n; i++)
                push_vtx(rand_coord(lim), rand_coord(lim), i == n - 1);
            items -= n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        win_w = WIDTH_RST;
        win_h = HEIGHT_RST;
        poly_drop = 1'b0;
        mismatches = 0;
        failed = 1'b0;
        quiet_cycles = 0;
        idle_pct_in = 27;
        idle_pct_out = 27;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: inside, straddling every edge, extremes, boundary points, overflow
        push_vtx(10, 10, 0); push_vtx(100, 10, 0); push_vtx(50, 90, 1);
        push_vtx(-50, -50, 0); push_vtx(700, -20, 0); push_vtx(700, 500, 0);
        push_vtx(-30, 520, 1);
        push_vtx(0, 0, 0); push_vtx(640, 0, 0); push_vtx(640, 480, 0); push_vtx(0, 480, 1);
        push_vtx(-32768, -32768, 0); push_vtx(32767, 32767, 1);
        push_vtx(-100, -100, 1);
        push_vtx(32767, -32768, 0); push_vtx(-32768, 32767, 1);
        for (int i = 0; i < 18; i++)
            push_vtx(320 + (i % 2 ? 400 : -400), 240 + i * 30 - 270, i == 17);
        drain();

        reg_write(ADDR_WIDTH, 32'hFFFF_8001);
        reg_write(ADDR_HEIGHT, 32'd1);
        random_polygons(100);
        drain();

        reg_write(ADDR_WIDTH, 32'd32767);
        reg_write(ADDR_HEIGHT, 32'd32767);
        idle_pct_in = 0;
        idle_pct_out = 0;
        random_polygons(100);
        drain();

        reg_write(ADDR_WIDTH, 32'd0);
        reg_write(ADDR_HEIGHT, 32'd0);
        idle_pct_in = 27;
        idle_pct_out = 27;
        random_polygons(50);
        drain();

        reg_write(ADDR_WIDTH, 32'd300);
        reg_write(ADDR_HEIGHT, 32'd200);
        random_polygons(250);
        drain();

        if (failed || expected_clips.size() > 0)
            $display("simulation failed");
        else
            $display("simulation ok");
        $finish;
    end
endmodule
